### rtl/core/shp3_pkg.sv
// ----------------------------------------------------------------------------
// shp3_pkg
// Shared types, constants and the per-channel kernel for the 3x3 sharpen core.
// ----------------------------------------------------------------------------
package shp3_pkg;

	// default build limits
	localparam int MAX_WIDTH_DEF    = 2048;
	localparam int MAX_CHANNELS_DEF = 3;

	// width used for position compares (covers any supported line length)
	localparam int POS_W = 13;

	// register reset values
	localparam logic [11:0] IMAGE_WIDTH_RST   = 12'd640;
	localparam logic [11:0] IMAGE_HEIGHT_RST  = 12'd480;
	localparam logic [1:0]  CHANNEL_COUNT_RST = 2'd3;

	// register map
	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	// result slots an input pixel can open, in emission order
	localparam int RES_INNER    = 0;
	localparam int RES_LAST_COL = 1;
	localparam int RES_LAST_ROW = 2;

	typedef struct packed {
		logic [7:0] chan0_in;
		logic [7:0] chan1_in;
		logic [7:0] chan2_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0]  chan0_out;
		logic [7:0]  chan1_out;
		logic [7:0]  chan2_out;
		logic [11:0] out_row;
		logic [10:0] out_col;
		logic        last_of_run;
	} pix_out_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [11:0] wr_data;
	} cfg_req_t;

	// the center scaled by five, less its left, right, up and down neighbors, clipped to 0..255
	function automatic logic [7:0] sharpen(input logic [7:0] ctr, input logic [7:0] lft,
	                                       input logic [7:0] rgt, input logic [7:0] up,
	                                       input logic [7:0] dn);
		logic [10:0]        five;
		logic [9:0]         nsum;
		logic signed [12:0] s;
		five = {1'b0, ctr, 2'b00} + {3'b000, ctr};
		nsum = {2'b00, lft} + {2'b00, rgt} + {2'b00, up} + {2'b00, dn};
		s = $signed({2'b00, five}) - $signed({3'b000, nsum});
		if (s < 13'sd0) begin
			return 8'd0;
		end else if (s > 13'sd255) begin
			return 8'd255;
		end
		return s[7:0];
	endfunction

endpackage

### rtl/core/shp3_stream_if.sv
// ----------------------------------------------------------------------------
// shp3_stream_if
// Valid/ready channel with a typed payload; source drives, sink accepts.
// ----------------------------------------------------------------------------
interface shp3_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/sharpen_3x3_filter_core.sv
// ----------------------------------------------------------------------------
// sharpen_3x3_filter_core
// 3x3 Laplacian sharpen over a raster pixel stream with two line buffers.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on pix_in, up to three 8-bit channels each.
// Each accepted pixel at (r,c) releases the sharpened pixel (r-1,c-1), plus a
// zero result for (r-1,c) when c is the last column and a zero result for
// (r,c) when r is the last row; border pixels and unused channels read zero,
// and last_of_run flags the final result of each request. The block takes
// one pixel per clock as long as each pixel yields at most one result and
// the output is not stalled; a pixel with several results (last column or
// last row) holds input while the single output register takes them one by one.
// A pixel passes through the line-buffer read (stage 1) and then the output
// register. The line buffers live in one RAM (one read, one write per clock)
// with no clearing after reset; unwritten entries only feed border pixels.
// Configuration writes (cfg) are always ready and take effect at once; they
// are expected only while the stream is idle.
// ----------------------------------------------------------------------------
module sharpen_3x3_filter_core #(
	parameter int MAX_WIDTH    = shp3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_CHANNELS = shp3_pkg::MAX_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	shp3_stream_if.sink   pix_in,
	shp3_stream_if.source pix_out,
	shp3_stream_if.sink   cfg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = shp3_pkg::POS_W;
	localparam int OL = (MAX_CHANNELS > 3) ? MAX_CHANNELS : 3;
	localparam logic [11:0] WMAX = (MAX_WIDTH > 4095) ? 12'd4095 : 12'(MAX_WIDTH);

	typedef logic [MAX_CHANNELS-1:0][7:0] lanes_t;
	typedef logic [1:0][MAX_CHANNELS-1:0][7:0] line_t; // [1] row r-2, [0] row r-1

	// ---------------- configuration registers ----------------
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [1:0]  chans_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= shp3_pkg::IMAGE_WIDTH_RST;
			height_q <= shp3_pkg::IMAGE_HEIGHT_RST;
			chans_q  <= shp3_pkg::CHANNEL_COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.payload.reg_index)
				shp3_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg.payload.wr_data;
				shp3_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg.payload.wr_data;
				shp3_pkg::REG_CHANNEL_COUNT: chans_q  <= cfg.payload.wr_data[1:0];
				default: ; // unmapped index: dropped
			endcase
		end
	end

	// effective sizes, clamped to what the hardware supports
	logic [11:0] w_used;
	logic [11:0] h_used;
	logic [2:0]  nch;

	always_comb begin
		if (width_q < 12'd3) begin
			w_used = 12'd3;
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_used = WMAX;
		end else begin
			w_used = width_q;
		end
		h_used = (height_q < 12'd3) ? 12'd3 : height_q;
		nch = (chans_q == 2'd0) ? 3'd1 : {1'b0, chans_q};
		if (32'(nch) > MAX_CHANNELS) begin
			nch = 3'(MAX_CHANNELS);
		end
	end

	// ---------------- position tracking ----------------
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;

	logic [PW-1:0] w_ext;
	logic          wrap_c;
	logic [CW-1:0] c_n;
	logic [11:0]   r_inc;
	logic [11:0]   r_n;
	logic [PW-1:0] c_p1;
	logic          end_row;
	logic [12:0]   r_p1;
	logic [CW-1:0] col_d;
	logic [11:0]   row_d;
	logic          last_col_n;
	logic          last_row_n;
	logic          border_n;
	logic [2:0]    pend_n;

	always_comb begin
		w_ext = PW'(w_used);
		// a stale position past the current size rolls over first
		wrap_c = PW'(col_q) >= w_ext;
		c_n    = wrap_c ? '0 : col_q;
		r_inc  = wrap_c ? row_q + 12'd1 : row_q;
		r_n    = (r_inc >= h_used) ? '0 : r_inc;

		c_p1    = PW'(c_n) + PW'(1);
		end_row = c_p1 >= w_ext;
		r_p1    = {1'b0, r_n} + 13'd1;
		col_d   = end_row ? '0 : c_p1[CW-1:0];
		if (!end_row) begin
			row_d = r_n;
		end else if (r_p1 >= {1'b0, h_used}) begin
			row_d = '0;
		end else begin
			row_d = r_p1[11:0];
		end

		last_col_n = PW'(c_n) == (w_ext - PW'(1));
		last_row_n = r_n == (h_used - 12'd1);
		border_n   = (r_n == 12'd1) || (c_n == CW'(1));

		pend_n = '0;
		pend_n[shp3_pkg::RES_INNER]    = (r_n != '0) && (c_n != '0);
		pend_n[shp3_pkg::RES_LAST_COL] = (r_n != '0) && last_col_n;
		pend_n[shp3_pkg::RES_LAST_ROW] = last_row_n;
	end

	// incoming samples, unused channels forced to zero
	logic [OL-1:0][7:0] in_pad;
	lanes_t             cur_n;

	always_comb begin
		in_pad    = '0;
		in_pad[0] = pix_in.payload.chan0_in;
		in_pad[1] = pix_in.payload.chan1_in;
		in_pad[2] = pix_in.payload.chan2_in;
		for (int k = 0; k < MAX_CHANNELS; k++) begin
			cur_n[k] = (3'(k) < nch) ? in_pad[k] : 8'd0;
		end
	end

	// ---------------- stage 1: pixel plus line-buffer read ----------------
	logic          v_s1;
	logic [2:0]    pend_s1;
	lanes_t        cur_s1;
	logic [11:0]   r_s1;
	logic [CW-1:0] c_s1;
	logic          border_s1;
	line_t         rd_s1;

	// window: left/center from the middle row, up/down at column c-1
	lanes_t win_left_q;
	lanes_t win_ctr_q;
	lanes_t win_up_q;
	lanes_t win_dn_q;

	line_t line_mem [MAX_WIDTH];

	logic     out_v_q;
	shp3_pkg::pix_out_t out_q;

	logic       slot_free;
	logic [2:0] sel_oh;
	logic [2:0] pend_next;
	logic       load;
	logic       done;
	logic       in_ready;
	logic       accept;

	always_comb begin
		slot_free = !out_v_q || pix_out.ready;
		if (pend_s1[shp3_pkg::RES_INNER]) begin
			sel_oh = 3'(1) << shp3_pkg::RES_INNER;
		end else if (pend_s1[shp3_pkg::RES_LAST_COL]) begin
			sel_oh = 3'(1) << shp3_pkg::RES_LAST_COL;
		end else if (pend_s1[shp3_pkg::RES_LAST_ROW]) begin
			sel_oh = 3'(1) << shp3_pkg::RES_LAST_ROW;
		end else begin
			sel_oh = '0;
		end
		pend_next = pend_s1 & ~sel_oh;
		load      = v_s1 && (pend_s1 != '0) && slot_free;
		// pixel retires when its last result moves out (or it had none)
		done      = v_s1 && ((pend_s1 == '0) || (load && (pend_next == '0)));
		in_ready  = !v_s1 || done;
		accept    = pix_in.valid && in_ready;
	end

	assign pix_in.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			pend_s1 <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (accept) begin
				v_s1    <= 1'b1;
				pend_s1 <= pend_n;
				col_q   <= col_d;
				row_q   <= row_d;
			end else begin
				if (done) begin
					v_s1 <= 1'b0;
				end
				if (load) begin
					pend_s1 <= pend_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1    <= cur_n;
			r_s1      <= r_n;
			c_s1      <= c_n;
			border_s1 <= border_n;
		end
	end

	// line buffers: read the new column on accept, write back on retire
	line_t wr_line;

	always_comb begin
		wr_line[1] = rd_s1[0];
		wr_line[0] = cur_s1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[c_n];
		end
		if (done) begin
			line_mem[c_s1] <= wr_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q <= '0;
			win_ctr_q  <= '0;
			win_up_q   <= '0;
			win_dn_q   <= '0;
		end else if (done) begin
			win_left_q <= win_ctr_q;
			win_ctr_q  <= rd_s1[0];
			win_up_q   <= rd_s1[1];
			win_dn_q   <= cur_s1;
		end
	end

	// ---------------- kernel and result select ----------------
	logic [OL-1:0][7:0] sharp_pad;
	shp3_pkg::pix_out_t res;

	always_comb begin
		sharp_pad = '0;
		for (int k = 0; k < MAX_CHANNELS; k++) begin
			if ((3'(k) < nch) && !border_s1) begin
				sharp_pad[k] = shp3_pkg::sharpen(win_ctr_q[k], win_left_q[k], rd_s1[0][k],
				                                 win_up_q[k], win_dn_q[k]);
			end
		end

		res = '0;
		res.last_of_run = pend_next == '0;
		if (sel_oh[shp3_pkg::RES_INNER]) begin
			res.chan0_out = sharp_pad[0];
			res.chan1_out = sharp_pad[1];
			res.chan2_out = sharp_pad[2];
			res.out_row   = r_s1 - 12'd1;
			res.out_col   = 11'(c_s1 - CW'(1));
		end else if (sel_oh[shp3_pkg::RES_LAST_COL]) begin
			res.out_row = r_s1 - 12'd1;
			res.out_col = 11'(c_s1);
		end else begin
			// last-row zero for the pixel itself
			res.out_row = r_s1;
			res.out_col = 11'(c_s1);
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign pix_out.valid   = out_v_q;
	assign pix_out.payload = out_q;

	// ---------------- checks ----------------
	// read and write of the line RAM in one clock never hit the same column
	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done) |-> (c_n != c_s1))
		else $error("line buffer read and write hit the same column");

	// a held pixel always sits inside the current line
	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (PW'(c_s1) < w_ext))
		else $error("stage 1 column outside the image width");

	// a pixel that retires without a new one leaves stage 1 empty
	a_retire_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accept) |=> (!v_s1 && (pend_s1 == '0)))
		else $error("stage 1 not cleared after retire");

	// every result row lies inside the image
	a_row_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.out_row < h_used))
		else $error("result row outside the image height");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 sharpen core.
// Pixels are streamed in through a valid/ready channel. Each accepted request
// is run through a local line-buffer model, which queues the pixels the core
// must release. Every result on the output channel is compared field by field
// with the oldest queued pixel.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          MAX_W      = shp3_pkg::MAX_WIDTH_DEF;
	localparam int          PRE_W      = 64;       // widest line the random part uses
	localparam int          RAND_ITEMS = 250;      // random pixels, small frames
	localparam int          WIDE_ITEMS = 2 * PRE_W + 8;
	localparam int          DRAIN_CYC  = 4;        // stage 1 and output register, plus slack
	localparam int          TAIL_CYC   = 12;       // watch for stray results at the end
	localparam int          HOLD_CYC   = 300;      // long output back-pressure
	localparam int          HOLD_W     = 4;        // narrow line for the stalled burst
	localparam int          HOLD_LEN   = 80;       // pixels offered during the stall
	localparam int          LIMIT_CYC  = 1_000_000;
	localparam logic [1:0]  REG_UNUSED = 2'd3;     // not in the register map

	typedef logic [2:0][7:0] rgb_t;    // [k] is channel k

	typedef enum logic {
		STEP_CFG,
		STEP_PIX
	} step_kind_t;

	// One row of the directed plan. chk marks the row whose first result has
	// its channels written out by hand.
	typedef struct packed {
		step_kind_t        kind;
		logic [1:0]        idx;
		logic [11:0]       data;
		shp3_pkg::pix_in_t px;
		logic              chk;
		logic [7:0]        e0;
		logic [7:0]        e1;
		logic [7:0]        e2;
	} plan_row_t;

	// Two 3x3 frames. The only interior pixel of a 3x3 frame is (1,1), so
	// the last request of each frame releases it along with two zero pixels.
	// Frame one: chan0 clips high (255*5), chan1 clips low (0 - 4*255),
	// chan2 lands inside (500 - 260). Frame two runs gray, with chan0 exactly
	// at 255 and the other channels forced to zero.
	localparam plan_row_t PLAN [0:22] = '{
		'{STEP_CFG, shp3_pkg::REG_IMAGE_WIDTH,   12'd0,   24'h0, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_CFG, shp3_pkg::REG_IMAGE_HEIGHT,  12'd2,   24'h0, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_CFG, shp3_pkg::REG_CHANNEL_COUNT, 12'd3,   24'h0, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_CFG, REG_UNUSED,                  12'hFFF, 24'h0, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'h80}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'h32}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'hFF, 8'h00, 8'h7F}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'h3C}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'hFF, 8'h00, 8'h64}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'h46}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'hFF, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'h50}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'h00, 8'h00}, 1'b1, 8'd255, 8'd0, 8'd240},
		'{STEP_CFG, shp3_pkg::REG_CHANNEL_COUNT, 12'd0,   24'h0, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h33, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'hFF}, 1'b0, 8'd0, 8'd0, 8'd0},
		'{STEP_PIX, 2'd0, 12'd0, {8'h00, 8'hFF, 8'hFF}, 1'b1, 8'd255, 8'd0, 8'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	shp3_stream_if #(.payload_t(shp3_pkg::pix_in_t))  pix_in_ch  ();
	shp3_stream_if #(.payload_t(shp3_pkg::pix_out_t)) pix_out_ch ();
	shp3_stream_if #(.payload_t(shp3_pkg::cfg_req_t)) cfg_ch     ();

	sharpen_3x3_filter_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_ch),
		.pix_out (pix_out_ch),
		.cfg     (cfg_ch)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// Line-buffer model: register copies, two previous rows, four samples around
	// the pixel one row and one column behind, and the next position.
	// ------------------------------------------------------------------------
	logic [11:0] img_w;
	logic [11:0] img_h;
	logic [1:0]  n_chan;
	rgb_t        line_two_up [MAX_W];   // row r-2
	rgb_t        line_one_up [MAX_W];   // row r-1
	rgb_t        nbhd [4];              // left, center, above, below of (r-1,c-1)
	int unsigned row_pos;
	int unsigned col_pos;

	shp3_pkg::pix_out_t expected_px [$];  // pixels the core still owes us

	int          src_idle_pct;
	int          snk_idle_pct;
	logic        hold_go = 1'b0;
	int          hold_cnt = 0;
	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;

	function automatic void queue_result(input rgb_t v, input int unsigned r,
	                                     input int unsigned c);
		shp3_pkg::pix_out_t res;
		res.chan0_out   = v[0];
		res.chan1_out   = v[1];
		res.chan2_out   = v[2];
		res.out_row     = r[11:0];
		res.out_col     = c[10:0];
		res.last_of_run = 1'b0;
		expected_px.push_back(res);
	endfunction

	// Advance the model by one accepted pixel; returns how many pixels it
	// released (0..3), already queued in emission order.
	function automatic int sharpen_step(input shp3_pkg::pix_in_t px);
		int unsigned w, h, nch, r, c;
		rgb_t        top, mid, cur, val;
		int          s;
		int          n;
		w   = (img_w < 3) ? 3 : ((img_w > MAX_W) ? MAX_W : img_w);
		h   = (img_h < 3) ? 3 : img_h;
		nch = (n_chan == 2'd0) ? 1 : n_chan;
		n   = 0;

		// a size change may leave the position outside the frame
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) begin
			row_pos = 0;
		end
		r = row_pos;
		c = col_pos;

		top = line_two_up[c];
		mid = line_one_up[c];
		cur = {px.chan2_in, px.chan1_in, px.chan0_in};
		for (int k = 0; k < 3; k++) begin
			if (k >= nch) begin
				cur[k] = 8'd0;
			end
		end

		if (r >= 1 && c >= 1) begin
			val = '0;
			// row 0 and column 0 are border, always zero
			if (r != 1 && c != 1) begin
				for (int k = 0; k < nch; k++) begin
					s = 5 * int'(nbhd[1][k]) - int'(nbhd[0][k]) - int'(mid[k])
					    - int'(nbhd[2][k]) - int'(nbhd[3][k]);
					val[k] = (s < 0) ? 8'd0 : ((s > 255) ? 8'd255 : s[7:0]);
				end
			end
			queue_result(val, r - 1, c - 1);
			n++;
		end
		if (r >= 1 && c == w - 1) begin
			queue_result('0, r - 1, c);     // last column of the row above
			n++;
		end
		if (r == h - 1) begin
			queue_result('0, r, c);         // last row goes out as it arrives
			n++;
		end
		if (n > 0) begin
			expected_px[expected_px.size() - 1].last_of_run = 1'b1;
		end

		nbhd[0] = nbhd[1];
		nbhd[1] = mid;
		nbhd[2] = top;
		nbhd[3] = cur;
		line_two_up[c] = mid;
		line_one_up[c] = cur;

		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) begin
				row_pos = 0;
			end
		end
		return n;
	endfunction

	// extremes are drawn often so both clip limits get hit
	function automatic logic [7:0] rand_sample();
		case ($urandom_range(3))
			0: begin
				return 8'd0;
			end
			1: begin
				return 8'd255;
			end
			default: begin
				return 8'($urandom_range(255));
			end
		endcase
	endfunction

	function automatic shp3_pkg::pix_in_t rand_pixel();
		shp3_pkg::pix_in_t p;
		p.chan0_in = rand_sample();
		p.chan1_in = rand_sample();
		p.chan2_in = rand_sample();
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Request helpers. Everything is driven with NBAs right after a rising
	// edge; ready is read at the edge, before the edge's own updates land.
	// ------------------------------------------------------------------------

	// Drop pix valid and wait until the core has released everything owed,
	// then a few more clocks: a row-0 request may still be in flight with no
	// result to show for it.
	task automatic wait_idle();
		pix_in_ch.valid <= 1'b0;
		while (expected_px.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
		wait_idle();
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= '{reg_index: idx, wr_data: data};
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			shp3_pkg::REG_IMAGE_WIDTH: begin
				img_w = data;
			end
			shp3_pkg::REG_IMAGE_HEIGHT: begin
				img_h = data;
			end
			shp3_pkg::REG_CHANNEL_COUNT: begin
				n_chan = data[1:0];
			end
			default: begin
				// out of map, the core must ignore it
			end
		endcase
	endtask

	// Offer one pixel, with random gaps first; valid stays up between
	// back-to-back requests.
	task automatic push_pixel(input shp3_pkg::pix_in_t px, output int n);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in_ch.valid   <= 1'b1;
		pix_in_ch.payload <= px;
		do begin
			@(posedge clk);
		end while (!pix_in_ch.ready);
		n = sharpen_step(px);
	endtask

	// ------------------------------------------------------------------------
	// Output side: random back-pressure, one long hold once asked for, and
	// the compare against the oldest queued pixel.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		shp3_pkg::pix_out_t want;
		if (arst_n) begin
			if (pix_out_ch.valid && pix_out_ch.ready) begin
				if (expected_px.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("unexpected pixel r%0d c%0d (%0d %0d %0d)",
						         pix_out_ch.payload.out_row, pix_out_ch.payload.out_col,
						         pix_out_ch.payload.chan0_out, pix_out_ch.payload.chan1_out,
						         pix_out_ch.payload.chan2_out);
					end
				end else begin
					want = expected_px.pop_front();
					if (pix_out_ch.payload.chan0_out !== want.chan0_out ||
					    pix_out_ch.payload.chan1_out !== want.chan1_out ||
					    pix_out_ch.payload.chan2_out !== want.chan2_out ||
					    pix_out_ch.payload.out_row !== want.out_row ||
					    pix_out_ch.payload.out_col !== want.out_col ||
					    pix_out_ch.payload.last_of_run !== want.last_of_run) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("mismatch exp r%0d c%0d ch %0d %0d %0d last %0b",
							         want.out_row, want.out_col, want.chan0_out,
							         want.chan1_out, want.chan2_out, want.last_of_run);
							$display("         got r%0d c%0d ch %0d %0d %0d last %0b",
							         pix_out_ch.payload.out_row, pix_out_ch.payload.out_col,
							         pix_out_ch.payload.chan0_out,
							         pix_out_ch.payload.chan1_out,
							         pix_out_ch.payload.chan2_out,
							         pix_out_ch.payload.last_of_run);
						end
					end
				end
			end
			// the hold lets the core fill up and push back on pix_in
			if (hold_go && hold_cnt < HOLD_CYC) begin
				hold_cnt++;
				pix_out_ch.ready <= 1'b0;
			end else begin
				pix_out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYC) begin
			$display("timeout, %0d pixels still owed", expected_px.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int          nres;
		int          first;
		int          rand_items;
		int          len;
		int unsigned pick;
		logic [11:0] wval;
		logic [11:0] hval;

		arst_n             = 1'b0;
		pix_in_ch.valid    = 1'b0;
		pix_in_ch.payload  = '0;
		pix_out_ch.ready   = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.payload     = '0;

		img_w   = shp3_pkg::IMAGE_WIDTH_RST;
		img_h   = shp3_pkg::IMAGE_HEIGHT_RST;
		n_chan  = shp3_pkg::CHANNEL_COUNT_RST;
		for (int i = 0; i < MAX_W; i++) begin
			line_two_up[i] = '0;
			line_one_up[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			nbhd[i] = '0;
		end
		row_pos = 0;
		col_pos = 0;

		src_idle_pct = 25;
		snk_idle_pct = 74;
		rand_items   = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames; clamps on width/height/channels, ignored index
		foreach (PLAN[i]) begin
			if (PLAN[i].kind == STEP_CFG) begin
				write_reg(PLAN[i].idx, PLAN[i].data);
			end else begin
				push_pixel(PLAN[i].px, nres);
				if (PLAN[i].chk) begin
					first = expected_px.size() - nres;
					expected_px[first].chan0_out = PLAN[i].e0;
					expected_px[first].chan1_out = PLAN[i].e1;
					expected_px[first].chan2_out = PLAN[i].e2;
				end
			end
		end

		// Widest line of the random part: two whole rows plus a few interior
		// pixels. This writes every line-buffer column the random part can
		// reach, so later size changes never read an unwritten one.
		write_reg(shp3_pkg::REG_IMAGE_WIDTH, 12'(PRE_W));
		write_reg(shp3_pkg::REG_IMAGE_HEIGHT, 12'd3);
		write_reg(shp3_pkg::REG_CHANNEL_COUNT, 12'd3);
		repeat (WIDE_ITEMS) push_pixel(rand_pixel(), nres);

		// Random phases: new sizes at arbitrary positions, then a burst of
		// pixels. Most frames are tiny so many complete; a few are tall.
		while (rand_items < RAND_ITEMS) begin
			if (rand_items < RAND_ITEMS / 3) begin
				src_idle_pct = 25;
				snk_idle_pct = 74;
			end else if (rand_items < 2 * RAND_ITEMS / 3) begin
				src_idle_pct = 74;
				snk_idle_pct = 25;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end

			pick = $urandom_range(99);
			if (pick < 10) begin
				wval = 12'($urandom_range(2));
			end else if (pick < 15) begin
				wval = 12'($urandom_range(PRE_W, 11));
			end else begin
				wval = 12'($urandom_range(10, 3));
			end
			pick = $urandom_range(99);
			if (pick < 10) begin
				hval = 12'($urandom_range(2));
			end else if (pick < 16) begin
				hval = 12'd4095;
			end else begin
				hval = 12'($urandom_range(6, 3));
			end

			if ($urandom_range(3) != 0) begin
				write_reg(shp3_pkg::REG_IMAGE_WIDTH, wval);
			end
			if ($urandom_range(3) != 0) begin
				write_reg(shp3_pkg::REG_IMAGE_HEIGHT, hval);
			end
			if ($urandom_range(3) != 0) begin
				write_reg(shp3_pkg::REG_CHANNEL_COUNT, 12'($urandom_range(3)));
			end
			if ($urandom_range(9) == 0) begin
				write_reg(REG_UNUSED, 12'($urandom_range(4095)));
			end

			len = $urandom_range(80, 1);
			// one long output stall in the last phase, on a narrow line so
			// results pile up while pixels keep coming
			if (src_idle_pct == 0 && !hold_go) begin
				write_reg(shp3_pkg::REG_IMAGE_WIDTH, 12'(HOLD_W));
				hold_go <= 1'b1;
				len = HOLD_LEN;
			end
			repeat (len) push_pixel(rand_pixel(), nres);
			rand_items += len;
		end

		wait_idle();
		repeat (TAIL_CYC) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
